/* rtl/sbe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and decode helpers for the stack bytecode execute core.
// Used by the controller, the datapath and the top level.
package sbe_pkg;

  localparam int SBE_STACK_DEPTH = 256;
  localparam int SBE_LOCAL_COUNT = 32;

  localparam int METHOD_LEN_W = 16;
  localparam int LIMIT_W    = 21;
  localparam int CFG_DATA_W = 21;
  localparam logic [15:0] METHOD_LEN_RESET = 16'd65535;
  localparam logic [20:0] LIMIT_RESET    = 21'd2000000;

  // Configuration register indexes.
  localparam logic CFG_CODE_LENGTH = 1'b0;
  localparam logic CFG_INSTR_LIMIT = 1'b1;

  // Input actions.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_RUN      = 4'd0;
  localparam logic [3:0] ST_RET_VOID = 4'd1;
  localparam logic [3:0] ST_RET_VAL  = 4'd2;
  localparam logic [3:0] ST_UNSUP    = 4'd3;
  localparam logic [3:0] ST_DIV_ZERO = 4'd4;
  localparam logic [3:0] ST_STACK    = 4'd5;
  localparam logic [3:0] ST_LOCAL    = 4'd6;
  localparam logic [3:0] ST_TIMEOUT  = 4'd7;
  localparam logic [3:0] ST_END      = 4'd8;

  // Comparison kinds, in the order the branch opcodes use them.
  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;

  // Opcodes.
  localparam logic [7:0] OP_NOP         = 8'h00;
  localparam logic [7:0] OP_ACONST_NULL = 8'h01;
  localparam logic [7:0] OP_ICONST_M1   = 8'h02;
  localparam logic [7:0] OP_ICONST_0    = 8'h03;
  localparam logic [7:0] OP_ICONST_5    = 8'h08;
  localparam logic [7:0] OP_BIPUSH      = 8'h10;
  localparam logic [7:0] OP_SIPUSH      = 8'h11;
  localparam logic [7:0] OP_ILOAD       = 8'h15;
  localparam logic [7:0] OP_ALOAD       = 8'h19;
  localparam logic [7:0] OP_ILOAD_0     = 8'h1a;
  localparam logic [7:0] OP_ILOAD_3     = 8'h1d;
  localparam logic [7:0] OP_ALOAD_0     = 8'h2a;
  localparam logic [7:0] OP_ALOAD_3     = 8'h2d;
  localparam logic [7:0] OP_ISTORE      = 8'h36;
  localparam logic [7:0] OP_ASTORE      = 8'h3a;
  localparam logic [7:0] OP_ISTORE_0    = 8'h3b;
  localparam logic [7:0] OP_ISTORE_3    = 8'h3e;
  localparam logic [7:0] OP_ASTORE_0    = 8'h4b;
  localparam logic [7:0] OP_ASTORE_3    = 8'h4e;
  localparam logic [7:0] OP_POP         = 8'h57;
  localparam logic [7:0] OP_POP2        = 8'h58;
  localparam logic [7:0] OP_DUP         = 8'h59;
  localparam logic [7:0] OP_DUP_X1      = 8'h5a;
  localparam logic [7:0] OP_IADD        = 8'h60;
  localparam logic [7:0] OP_ISUB        = 8'h64;
  localparam logic [7:0] OP_IMUL        = 8'h68;
  localparam logic [7:0] OP_IDIV        = 8'h6c;
  localparam logic [7:0] OP_IREM        = 8'h70;
  localparam logic [7:0] OP_INEG        = 8'h74;
  localparam logic [7:0] OP_ISHL        = 8'h78;
  localparam logic [7:0] OP_ISHR        = 8'h7a;
  localparam logic [7:0] OP_IUSHR       = 8'h7c;
  localparam logic [7:0] OP_IAND        = 8'h7e;
  localparam logic [7:0] OP_IOR         = 8'h80;
  localparam logic [7:0] OP_IXOR        = 8'h82;
  localparam logic [7:0] OP_IINC        = 8'h84;
  localparam logic [7:0] OP_I2B         = 8'h91;
  localparam logic [7:0] OP_I2C         = 8'h92;
  localparam logic [7:0] OP_I2S         = 8'h93;
  localparam logic [7:0] OP_IFEQ        = 8'h99;
  localparam logic [7:0] OP_IFLE        = 8'h9e;
  localparam logic [7:0] OP_IF_ICMPEQ   = 8'h9f;
  localparam logic [7:0] OP_IF_ICMPLE   = 8'ha4;
  localparam logic [7:0] OP_IF_ACMPEQ   = 8'ha5;
  localparam logic [7:0] OP_IF_ACMPNE   = 8'ha6;
  localparam logic [7:0] OP_GOTO        = 8'ha7;
  localparam logic [7:0] OP_IRETURN     = 8'hac;
  localparam logic [7:0] OP_ARETURN     = 8'hb0;
  localparam logic [7:0] OP_RETURN      = 8'hb1;
  localparam logic [7:0] OP_IFNULL      = 8'hc6;
  localparam logic [7:0] OP_IFNONNULL   = 8'hc7;

  typedef struct packed {
    logic       ok;
    logic [1:0] po;
    logic [1:0] pu;
    logic [1:0] len;
  } shape_t;

  // Controller to datapath.
  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic       rd_second;
    logic       cap_a0;
    logic       cap_a1;
    logic       div_start;
    logic       cap_res;
    logic       wr_en;
    logic [1:0] wr_idx;
    logic       commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       run;
    logic [1:0] po;
    logic [1:0] pu;
    logic       is_div;
    logic       div_zero;
    logic       div_done;
    logic       out_free;
  } sts_t;

  function automatic shape_t sbe_shape(input logic [7:0] op);
    shape_t s;
    s = '{ok: 1'b1, po: 2'd0, pu: 2'd0, len: 2'd1};
    case (op) inside
      OP_NOP: ;
      [OP_ACONST_NULL:OP_ICONST_5], [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3]:
        s.pu = 2'd1;
      OP_BIPUSH, OP_ILOAD, OP_ALOAD: begin
        s.pu = 2'd1;
        s.len = 2'd2;
      end
      OP_SIPUSH: begin
        s.pu = 2'd1;
        s.len = 2'd3;
      end
      OP_ISTORE, OP_ASTORE: begin
        s.po = 2'd1;
        s.len = 2'd2;
      end
      [OP_ISTORE_0:OP_ISTORE_3], [OP_ASTORE_0:OP_ASTORE_3], OP_POP,
      OP_IRETURN, OP_ARETURN:
        s.po = 2'd1;
      OP_IINC, OP_GOTO:
        s.len = 2'd3;
      OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR, OP_IUSHR,
      OP_IAND, OP_IOR, OP_IXOR: begin
        s.po = 2'd2;
        s.pu = 2'd1;
      end
      OP_INEG, OP_I2B, OP_I2C, OP_I2S: begin
        s.po = 2'd1;
        s.pu = 2'd1;
      end
      OP_POP2:
        s.po = 2'd2;
      OP_DUP: begin
        s.po = 2'd1;
        s.pu = 2'd2;
      end
      OP_DUP_X1: begin
        s.po = 2'd2;
        s.pu = 2'd3;
      end
      OP_RETURN: ;
      [OP_IFEQ:OP_IFLE], OP_IFNULL, OP_IFNONNULL: begin
        s.po = 2'd1;
        s.len = 2'd3;
      end
      [OP_IF_ICMPEQ:OP_IF_ACMPNE]: begin
        s.po = 2'd2;
        s.len = 2'd3;
      end
      default: s.ok = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic sbe_test(input logic [2:0] k, input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    logic t;
    case (k)
      CMP_EQ:  t = (a == b);
      CMP_NE:  t = (a != b);
      CMP_LT:  t = (a < b);
      CMP_GE:  t = (a >= b);
      CMP_GT:  t = (a > b);
      default: t = (a <= b);
    endcase
    return t;
  endfunction

  function automatic logic [31:0] sbe_sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [31:0] sbe_sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

endpackage

/* rtl/stack_bytecode_execute_core.sv */
`timescale 1ns / 1ps
// Top level of the stack bytecode execute core: controller plus datapath.
// Depends on sbe_pkg, sbe_ctrl and sbe_datapath.
//
// The host streams items on the in_ channel: a start-frame item clears the
// program counter, stack pointer, instruction count and locals; argument items
// fill one local; execute items carry the opcode at the current program counter
// and the two bytes after it. Every item yields exactly one transfer on the out_
// channel with the next program counter, a status and a return value.
// Configuration writes (code length, instruction limit) are taken on any cycle
// on which cfg_we is high and should only be issued while the block is idle.
//
// One item is handled at a time. Start, argument and rejected execute items go
// from acceptance through decode to the finish state. An executed instruction
// passes through decode, one read state per stack entry read (0 to 2), the
// execute step, one write state per entry pushed (0 to 3), and for divide and
// remainder a wait on the one-bit-per-cycle divider, before the finish state.
// The single read and single write port of the stack memory are why entries are
// read and written one at a time.
// A finished result sits in an output register; the block accepts the next item
// while it waits, but holds the following result until the receiver takes the
// pending one. Reset returns the state machine to idle, zeroes the program
// counter, stack pointer, count and locals and restores the default registers.
// The stack memory is not cleared; entries are always written before being read.
module stack_bytecode_execute_core #(
  parameter int STACK_DEPTH = sbe_pkg::SBE_STACK_DEPTH,
  parameter int LOCAL_COUNT = sbe_pkg::SBE_LOCAL_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [sbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // From bit 0: action[2], opcode[8], operand_high[8], operand_low[8],
  // local_index[5], arg_value[32], one zero pad bit.
  input  logic [63:0]                    in_tdata,
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // From bit 0: next_pc[16], status[4], return_value[32], four zero pad bits.
  output logic [55:0]                    out_tdata
);
  import sbe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbe_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCAL_COUNT (LOCAL_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/sbe_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/sbe_div.sv */
`timescale 1ns / 1ps
// Iterative signed 32-bit divider, one quotient bit per cycle.
// No dependencies.
module sbe_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] rem_r, quo_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r, neg_q_r, neg_r_r;
  logic [32:0] shifted, diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Work on magnitudes; the most negative value maps to 2^31, which fits.
      quo_r   <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_r   <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem_r   <= '0;
      neg_q_r <= dividend[31] ^ divisor[31];
      neg_r_r <= dividend[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (32'd0 - quo_r) : quo_r;
  assign remainder = neg_r_r ? (32'd0 - rem_r) : rem_r;

endmodule

/* rtl/sbe_datapath.sv */
`timescale 1ns / 1ps
// Datapath: architectural state, stack memory, locals, ALU and output register.
// Depends on sbe_pkg, sbe_ram and sbe_div.
module sbe_datapath #(
  parameter int STACK_DEPTH = sbe_pkg::SBE_STACK_DEPTH,
  parameter int LOCAL_COUNT = sbe_pkg::SBE_LOCAL_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [sbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [63:0]                  in_tdata,
  input  sbe_pkg::cmd_t                cmd,
  output sbe_pkg::sts_t                sts,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [55:0]                  out_tdata
);
  import sbe_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(LOCAL_COUNT);
  localparam logic [SPW:0] DEPTH_X = (SPW + 1)'(STACK_DEPTH);
  localparam logic [8:0]   LC_X    = 9'(LOCAL_COUNT);

  // Latched item.
  logic [1:0]  act_r;
  logic [7:0]  op_r, hi_r, lo_r;
  logic [4:0]  idx_r;
  logic [31:0] arg_r;

  // Architectural state.
  logic [15:0]      pc_r, method_len_r;
  logic [LIMIT_W-1:0] cnt_r, lim_r;
  logic [SPW-1:0]   sp_r;
  logic [31:0]      loc_r [LOCAL_COUNT];

  // Work registers.
  logic [31:0] a0_r, a1_r, r0_r, r1_r, r2_r, rv_r, lres_r;
  logic [15:0] nxt_r;
  logic [3:0]  st_r;
  logic        ok_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_pc_r;
  logic [3:0]  out_st_r;
  logic [31:0] out_rv_r;

  shape_t      shp;
  logic        in_range, under_lim, sp_under, sp_over, loc_op, loc_bad, idx_bad;
  logic        is_lwrite, run, cnt_inc, is_div, div_zero, div_done, take;
  logic [3:0]  early_st, st_nxt;
  logic [SPW:0] sp_after;
  logic [7:0]  loc_k;
  logic [LW-1:0] loc_a;
  logic [31:0] loc_rd, res0, quo, rem, lres_nxt;
  logic [15:0] nxt;
  logic [4:0]  shamt;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data, rd_data;

  // ---------------- decode of the latched item ----------------
  assign shp       = sbe_shape(op_r);
  assign in_range  = pc_r < method_len_r;
  assign under_lim = cnt_r < lim_r;
  assign sp_under  = sp_r < SPW'(shp.po);
  assign sp_after  = {1'b0, sp_r} - (SPW + 1)'(shp.po) + (SPW + 1)'(shp.pu);
  assign sp_over   = sp_after > DEPTH_X;
  assign loc_op    = (op_r == OP_ILOAD) || (op_r == OP_ALOAD) || (op_r == OP_ISTORE) ||
                     (op_r == OP_ASTORE) || (op_r == OP_IINC);
  assign loc_bad   = loc_op && ({1'b0, hi_r} >= LC_X);
  assign idx_bad   = {4'b0, idx_r} >= LC_X;
  assign is_div    = (op_r == OP_IDIV) || (op_r == OP_IREM);
  assign div_zero  = is_div && (a0_r == 32'd0);

  always_comb begin
    early_st = ST_RUN;
    if (act_r == ACT_LOAD) begin
      if (idx_bad) early_st = ST_LOCAL;
    end else if (act_r == ACT_EXEC) begin
      if (!in_range)              early_st = ST_END;
      else if (!under_lim)        early_st = ST_TIMEOUT;
      else if (!shp.ok)           early_st = ST_UNSUP;
      else if (sp_under || sp_over) early_st = ST_STACK;
      else if (loc_bad)           early_st = ST_LOCAL;
    end
  end

  assign run     = (act_r == ACT_EXEC) && (early_st == ST_RUN);
  assign cnt_inc = (act_r == ACT_EXEC) && in_range && under_lim;

  // Local slot selected by the instruction.
  always_comb begin
    is_lwrite = 1'b0;
    case (op_r) inside
      [OP_ILOAD_0:OP_ILOAD_3]:   loc_k = op_r - OP_ILOAD_0;
      [OP_ALOAD_0:OP_ALOAD_3]:   loc_k = op_r - OP_ALOAD_0;
      [OP_ISTORE_0:OP_ISTORE_3]: begin
        loc_k = op_r - OP_ISTORE_0;
        is_lwrite = 1'b1;
      end
      [OP_ASTORE_0:OP_ASTORE_3]: begin
        loc_k = op_r - OP_ASTORE_0;
        is_lwrite = 1'b1;
      end
      OP_ISTORE, OP_ASTORE, OP_IINC: begin
        loc_k = hi_r;
        is_lwrite = 1'b1;
      end
      default: loc_k = hi_r;
    endcase
  end

  assign loc_a  = LW'(loc_k);
  assign loc_rd = loc_r[loc_a];

  assign sts = '{run: run, po: shp.po, pu: shp.pu, is_div: is_div, div_zero: div_zero,
                 div_done: div_done, out_free: !out_valid_r || out_tready};

  // ---------------- stack memory ----------------
  assign rd_addr = AW'(sp_r - (cmd.rd_second ? SPW'(2) : SPW'(1)));
  assign wr_addr = AW'(sp_r - SPW'(shp.po) + SPW'(cmd.wr_idx));

  always_comb begin
    case (cmd.wr_idx)
      2'd0:    wr_data = r0_r;
      2'd1:    wr_data = r1_r;
      default: wr_data = r2_r;
    endcase
  end

  sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (a1_r),
    .divisor   (a0_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // ---------------- ALU ----------------
  assign shamt = a0_r[4:0];

  always_comb begin
    case (op_r) inside
      [OP_ICONST_M1:OP_ICONST_5]: res0 = 32'(op_r) - 32'(OP_ICONST_0);
      OP_BIPUSH: res0 = sbe_sx8(hi_r);
      OP_SIPUSH: res0 = sbe_sx16({hi_r, lo_r});
      [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3], OP_ILOAD, OP_ALOAD: res0 = loc_rd;
      OP_IADD:  res0 = a1_r + a0_r;
      OP_ISUB:  res0 = a1_r - a0_r;
      OP_IMUL:  res0 = a1_r * a0_r;
      OP_IDIV:  res0 = quo;
      OP_IREM:  res0 = rem;
      OP_INEG:  res0 = 32'd0 - a0_r;
      OP_IAND:  res0 = a1_r & a0_r;
      OP_IOR:   res0 = a1_r | a0_r;
      OP_IXOR:  res0 = a1_r ^ a0_r;
      OP_ISHL:  res0 = a1_r << shamt;
      OP_ISHR:  res0 = 32'($signed(a1_r) >>> shamt);
      OP_IUSHR: res0 = a1_r >> shamt;
      OP_I2B:   res0 = sbe_sx8(a0_r[7:0]);
      OP_I2C:   res0 = {16'd0, a0_r[15:0]};
      OP_I2S:   res0 = sbe_sx16(a0_r[15:0]);
      OP_ACONST_NULL: res0 = 32'd0;
      default:  res0 = a0_r;
    endcase
  end

  always_comb begin
    case (op_r) inside
      [OP_IFEQ:OP_IFLE]:
        take = sbe_test(3'(op_r - OP_IFEQ), a0_r, 32'sd0);
      [OP_IF_ICMPEQ:OP_IF_ICMPLE]:
        take = sbe_test(3'(op_r - OP_IF_ICMPEQ), a1_r, a0_r);
      OP_IF_ACMPEQ, OP_IF_ACMPNE:
        take = sbe_test(3'(op_r - OP_IF_ACMPEQ), a1_r, a0_r);
      OP_IFNULL, OP_IFNONNULL:
        take = sbe_test(3'(op_r - OP_IFNULL), a0_r, 32'sd0);
      OP_GOTO: take = 1'b1;
      default: take = 1'b0;
    endcase
  end

  assign nxt      = take ? (pc_r + {hi_r, lo_r}) : (pc_r + 16'(shp.len));
  assign lres_nxt = (op_r == OP_IINC) ? (loc_rd + sbe_sx8(lo_r)) : a0_r;

  always_comb begin
    if (div_zero) st_nxt = ST_DIV_ZERO;
    else if ((op_r == OP_IRETURN) || (op_r == OP_ARETURN)) st_nxt = ST_RET_VAL;
    else if (op_r == OP_RETURN) st_nxt = ST_RET_VOID;
    else if (nxt >= method_len_r) st_nxt = ST_END;
    else st_nxt = ST_RUN;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_tdata[1:0];
      op_r  <= in_tdata[9:2];
      hi_r  <= in_tdata[17:10];
      lo_r  <= in_tdata[25:18];
      idx_r <= in_tdata[30:26];
      arg_r <= in_tdata[62:31];
    end
    if (cmd.cap_a0) a0_r <= rd_data;
    if (cmd.cap_a1) a1_r <= rd_data;
    if (cmd.cap_res) begin
      r0_r   <= res0;
      r1_r   <= (op_r == OP_DUP_X1) ? a1_r : a0_r;
      r2_r   <= a0_r;
      nxt_r  <= nxt;
      st_r   <= st_nxt;
      rv_r   <= (st_nxt == ST_RET_VAL) ? a0_r : 32'd0;
      lres_r <= lres_nxt;
      ok_r   <= !div_zero;
    end
  end

  // ---------------- commit ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_len_r <= METHOD_LEN_RESET;
      lim_r       <= LIMIT_RESET;
      pc_r        <= '0;
      sp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LOCAL_COUNT; i++) loc_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_CODE_LENGTH) method_len_r <= cfg_wdata[METHOD_LEN_W-1:0];
        else                             lim_r        <= cfg_wdata[LIMIT_W-1:0];
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        out_pc_r    <= pc_r;
        out_st_r    <= early_st;
        out_rv_r    <= 32'd0;
        case (act_r)
          ACT_START: begin
            pc_r     <= '0;
            sp_r     <= '0;
            cnt_r    <= '0;
            out_pc_r <= '0;
            for (int i = 0; i < LOCAL_COUNT; i++) loc_r[i] <= '0;
          end
          ACT_LOAD: begin
            if (!idx_bad) loc_r[LW'(idx_r)] <= arg_r;
          end
          ACT_EXEC: begin
            if (cnt_inc) cnt_r <= cnt_r + LIMIT_W'(1);
            if (run) begin
              out_st_r <= st_r;
              if (ok_r) begin
                pc_r     <= nxt_r;
                sp_r     <= SPW'(sp_after);
                out_pc_r <= nxt_r;
                out_rv_r <= rv_r;
                if (is_lwrite) loc_r[loc_a] <= lres_r;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rv_r, out_st_r, out_pc_r};

endmodule

/* rtl/sbe_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences decode, stack reads, divide, writes, commit.
// Depends on sbe_pkg.
module sbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sbe_pkg::sts_t sts,
  output sbe_pkg::cmd_t cmd
);
  import sbe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_EXE  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] wcnt_r, wcnt_nxt;

  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    cmd       = '0;
    cmd.wr_idx = wcnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.run) begin
          state_nxt = S_FIN;
        end else if (sts.po != 2'd0) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_RD1;
        end else begin
          state_nxt = S_EXE;
        end
      end
      S_RD1: begin
        cmd.cap_a0 = 1'b1;
        if (sts.po == 2'd2) begin
          cmd.rd_en     = 1'b1;
          cmd.rd_second = 1'b1;
          state_nxt     = S_RD2;
        end else begin
          state_nxt = S_EXE;
        end
      end
      S_RD2: begin
        cmd.cap_a1 = 1'b1;
        state_nxt  = S_EXE;
      end
      S_EXE: begin
        if (sts.is_div && !sts.div_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.cap_res = 1'b1;
          state_nxt   = (sts.pu != 2'd0 && !sts.div_zero) ? S_WR : S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.cap_res = 1'b1;
          state_nxt   = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_en = 1'b1;
        if (wcnt_r == sts.pu - 2'd1) begin
          wcnt_nxt  = 2'd0;
          state_nxt = S_FIN;
        end else begin
          wcnt_nxt = wcnt_r + 2'd1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

/* dv/tb_stack_bytecode_execute_core.sv */
`timescale 1ns / 1ps
// Testbench for stack_bytecode_execute_core: directed and random instruction streams.
// A scoreboard class predicts every result; plain tasks drive the stream and config ports.
// Depends on sbe_pkg and the RTL of the core.
module tb_stack_bytecode_execute_core;
  import sbe_pkg::*;

  // The spare action code is not named in the package.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int DEPTH = 256;
  localparam int LOCALS = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [15:0] next_pc;
    logic [3:0]  status;
    logic [31:0] ret_val;
  } result_t;

  // Predicts one result per accepted item and checks results in order.
  class exec_scoreboard;
    logic [15:0] method_len = METHOD_LEN_RESET;
    logic [20:0] instr_limit = LIMIT_RESET;
    logic [15:0] pc;
    logic [31:0] stack_mem[DEPTH];
    int          sp;
    logic [31:0] locals[LOCALS];
    logic [20:0] exec_cnt;
    result_t     pending_q[$];
    int          errors;

    function new();
      pc = 0; sp = 0; exec_cnt = 0; errors = 0;
      foreach (locals[i]) locals[i] = 0;
    endfunction

    function void set_reg(logic idx, logic [20:0] val);
      if (idx == CFG_CODE_LENGTH) method_len = val[15:0];
      else instr_limit = val;
    endfunction

    // Stack effect and length of an opcode; returns 0 when unsupported.
    static function bit decode(logic [7:0] op, output int po, output int pu, output int ln);
      po = 0; pu = 0; ln = 1;
      if (op == OP_NOP || op == OP_RETURN) return 1;
      if (op inside {[OP_ACONST_NULL:OP_ICONST_5], [OP_ILOAD_0:OP_ILOAD_3],
                     [OP_ALOAD_0:OP_ALOAD_3]}) begin pu = 1; return 1; end
      if (op inside {OP_BIPUSH, OP_ILOAD, OP_ALOAD}) begin pu = 1; ln = 2; return 1; end
      if (op == OP_SIPUSH) begin pu = 1; ln = 3; return 1; end
      if (op inside {OP_ISTORE, OP_ASTORE}) begin po = 1; ln = 2; return 1; end
      if (op inside {[OP_ISTORE_0:OP_ISTORE_3], [OP_ASTORE_0:OP_ASTORE_3], OP_POP,
                     OP_IRETURN, OP_ARETURN}) begin po = 1; return 1; end
      if (op inside {OP_IINC, OP_GOTO}) begin ln = 3; return 1; end
      if (op inside {OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR,
                     OP_IUSHR, OP_IAND, OP_IOR, OP_IXOR}) begin po = 2; pu = 1; return 1; end
      if (op inside {OP_INEG, OP_I2B, OP_I2C, OP_I2S}) begin po = 1; pu = 1; return 1; end
      if (op == OP_POP2) begin po = 2; return 1; end
      if (op == OP_DUP) begin po = 1; pu = 2; return 1; end
      if (op == OP_DUP_X1) begin po = 2; pu = 3; return 1; end
      if (op inside {[OP_IFEQ:OP_IFLE], OP_IFNULL, OP_IFNONNULL}) begin
        po = 1; ln = 3; return 1;
      end
      if (op inside {[OP_IF_ICMPEQ:OP_IF_ACMPNE]}) begin po = 2; ln = 3; return 1; end
      return 0;
    endfunction

    static function bit compare(int k, logic signed [31:0] a, logic signed [31:0] b);
      case (k)
        CMP_EQ:  return a == b;
        CMP_NE:  return a != b;
        CMP_LT:  return a < b;
        CMP_GE:  return a >= b;
        CMP_GT:  return a > b;
        default: return a <= b;
      endcase
    endfunction

    function void push_result(logic [15:0] npc, logic [3:0] st, logic [31:0] rv);
      result_t r;
      r.next_pc = npc; r.status = st; r.ret_val = rv;
      pending_q.push_back(r);
    endfunction

    // Notes an accepted input transfer and queues the result it must produce.
    function void note(logic [63:0] d);
      logic [1:0]  act;
      logic [7:0]  op, hi, lo;
      logic [4:0]  idx;
      logic [31:0] a0, a1, rv;
      logic [31:0] res[3];
      logic [15:0] nxt;
      logic [4:0]  sh;
      logic [3:0]  st;
      int po, pu, ln;
      bit take;
      act = d[1:0]; op = d[9:2]; hi = d[17:10]; lo = d[25:18];
      idx = d[30:26];
      a0 = 0; a1 = 0; rv = 0; st = ST_RUN; res = '{0, 0, 0};
      if (act == ACT_START) begin
        pc = 0; sp = 0; exec_cnt = 0;
        foreach (locals[i]) locals[i] = 0;
        push_result(0, ST_RUN, 0);
        return;
      end
      if (act == ACT_LOAD) begin
        // A five-bit index always lands inside the locals.
        locals[idx] = d[62:31];
        push_result(pc, ST_RUN, 0);
        return;
      end
      if (act == ACT_SPARE) begin push_result(pc, ST_RUN, 0); return; end
      if (pc >= method_len) begin push_result(pc, ST_END, 0); return; end
      if (exec_cnt >= instr_limit) begin push_result(pc, ST_TIMEOUT, 0); return; end
      exec_cnt++;
      if (!decode(op, po, pu, ln)) begin push_result(pc, ST_UNSUP, 0); return; end
      if (sp < po || sp - po + pu > DEPTH) begin push_result(pc, ST_STACK, 0); return; end
      if (op inside {OP_ILOAD, OP_ALOAD, OP_ISTORE, OP_ASTORE, OP_IINC} && hi >= LOCALS)
      begin
        push_result(pc, ST_LOCAL, 0);
        return;
      end
      if (po >= 1) a0 = stack_mem[sp - 1];
      if (po >= 2) a1 = stack_mem[sp - 2];
      if (op inside {OP_IDIV, OP_IREM} && a0 == 0) begin
        push_result(pc, ST_DIV_ZERO, 0);
        return;
      end
      nxt = pc + 16'(ln);
      sh = a0[4:0];
      if (op inside {OP_ACONST_NULL, OP_ICONST_0}) res[0] = 0;
      else if (op inside {[OP_ICONST_M1:OP_ICONST_5]}) res[0] = {24'd0, op} - {24'd0, OP_ICONST_0};
      else if (op == OP_BIPUSH) res[0] = {{24{hi[7]}}, hi};
      else if (op == OP_SIPUSH) res[0] = {{16{hi[7]}}, hi, lo};
      else if (op inside {[OP_ILOAD_0:OP_ILOAD_3]}) res[0] = locals[op - OP_ILOAD_0];
      else if (op inside {[OP_ALOAD_0:OP_ALOAD_3]}) res[0] = locals[op - OP_ALOAD_0];
      else if (op inside {OP_ILOAD, OP_ALOAD}) res[0] = locals[hi];
      else if (op inside {[OP_ISTORE_0:OP_ISTORE_3]}) locals[op - OP_ISTORE_0] = a0;
      else if (op inside {[OP_ASTORE_0:OP_ASTORE_3]}) locals[op - OP_ASTORE_0] = a0;
      else if (op inside {OP_ISTORE, OP_ASTORE}) locals[hi] = a0;
      else if (op == OP_IINC) locals[hi] = locals[hi] + {{24{lo[7]}}, lo};
      else if (op == OP_IADD) res[0] = a1 + a0;
      else if (op == OP_ISUB) res[0] = a1 - a0;
      else if (op == OP_IMUL) res[0] = a1 * a0;
      else if (op inside {OP_IDIV, OP_IREM}) begin
        // The most negative value divided by minus one overflows back to itself.
        if (a1 == 32'h8000_0000 && a0 == 32'hffff_ffff)
          res[0] = (op == OP_IDIV) ? 32'h8000_0000 : 32'd0;
        else if (op == OP_IDIV) res[0] = $signed(a1) / $signed(a0);
        else res[0] = $signed(a1) % $signed(a0);
      end
      else if (op == OP_INEG) res[0] = -a0;
      else if (op == OP_IAND) res[0] = a1 & a0;
      else if (op == OP_IOR) res[0] = a1 | a0;
      else if (op == OP_IXOR) res[0] = a1 ^ a0;
      else if (op == OP_ISHL) res[0] = a1 << sh;
      else if (op == OP_ISHR) res[0] = $signed(a1) >>> sh;
      else if (op == OP_IUSHR) res[0] = a1 >> sh;
      else if (op == OP_DUP) begin res[0] = a0; res[1] = a0; end
      else if (op == OP_DUP_X1) begin res[0] = a0; res[1] = a1; res[2] = a0; end
      else if (op == OP_I2B) res[0] = {{24{a0[7]}}, a0[7:0]};
      else if (op == OP_I2C) res[0] = {16'd0, a0[15:0]};
      else if (op == OP_I2S) res[0] = {{16{a0[15]}}, a0[15:0]};
      else if (op == OP_GOTO || op inside {[OP_IFEQ:OP_IF_ACMPNE], OP_IFNULL, OP_IFNONNULL})
      begin
        if (op == OP_GOTO) take = 1;
        else if (op <= OP_IFLE) take = compare(op - OP_IFEQ, a0, 0);
        else if (op <= OP_IF_ICMPLE) take = compare(op - OP_IF_ICMPEQ, a1, a0);
        else if (op <= OP_IF_ACMPNE) take = compare(op - OP_IF_ACMPEQ, a1, a0);
        else take = compare(op - OP_IFNULL, a0, 0);
        if (take) nxt = pc + {hi, lo};
      end
      else if (op inside {OP_IRETURN, OP_ARETURN}) begin st = ST_RET_VAL; rv = a0; end
      else if (op == OP_RETURN) st = ST_RET_VOID;
      sp -= po;
      for (int i = 0; i < pu; i++) begin
        stack_mem[sp] = res[i];
        sp++;
      end
      pc = nxt;
      if (st == ST_RUN && nxt >= method_len) st = ST_END;
      push_result(nxt, st, rv);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
      errors++;
    endtask

    // Compares an accepted result transfer with the oldest prediction.
    task check(logic [55:0] d);
      result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", d[31:0], 0);
        return;
      end
      w = pending_q.pop_front();
      if (d[15:0] !== w.next_pc) report("next_pc", d[15:0], w.next_pc);
      if (d[19:16] !== w.status) report("status", d[19:16], w.status);
      if (d[51:20] !== w.ret_val) report("return_value", d[51:20], w.ret_val);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  exec_scoreboard sb = new();
  logic [7:0] known_ops[$];
  int tx_idle_pct, rx_stall_pct;
  bit hold_go;
  int push_left;

  stack_bytecode_execute_core dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always #4 clk = ~clk;

  // Both channels are observed at the edge; the check runs before the note so a
  // result can never be matched against the item accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check(out_tdata);
      if (in_tvalid && in_tready) sb.note(in_tdata);
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk) begin : receiver
    int hold_cnt;
    if (hold_go) begin
      hold_cnt = HOLD_CYCLES;
      hold_go = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] item(logic [1:0] act, logic [7:0] op, logic [7:0] hi,
                                       logic [7:0] lo, logic [4:0] idx, logic [31:0] arg);
    return {1'b0, arg, idx, lo, hi, op, act};
  endfunction

  // Offers one item, with random idle cycles first, and returns at the edge that
  // takes it. Called and returning at a rising edge.
  task automatic send(logic [63:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic exec_op(logic [7:0] op, logic [7:0] hi = 0, logic [7:0] lo = 0);
    send(item(ACT_EXEC, op, hi, lo, 0, 0));
  endtask

  // Sender pause until every predicted result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // One register write; drops the enable and waits for another edge before returning
  // so that back-to-back calls never drive the enable twice in the same step.
  task automatic write_reg(logic idx, logic [20:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Mostly well-formed execution with random content; frames restart now and then,
  // and long push runs drive the stack to overflow.
  task automatic random_item();
    int pick;
    logic [7:0] op, hi;
    pick = $urandom_range(99);
    hi = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(LOCALS - 1));
    if (push_left > 0) begin
      push_left--;
      exec_op($urandom_range(1) ? OP_DUP : OP_BIPUSH, 8'($urandom), 8'($urandom));
    end else if (pick < 3) begin
      send(item(ACT_START, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                $urandom));
    end else if (pick < 9) begin
      send(item(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                $urandom));
    end else if (pick < 10) begin
      send(item(ACT_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                $urandom));
    end else begin
      if (pick < 20) op = 8'($urandom);
      else if (sb.sp < 2 && pick < 70) op = OP_BIPUSH + 8'($urandom_range(1));
      else op = known_ops[$urandom_range(known_ops.size() - 1)];
      // Branch offsets are usually short so that programs keep running.
      if (op inside {[OP_IFEQ:OP_GOTO], OP_IFNULL, OP_IFNONNULL} && pick < 80)
        exec_op(op, $urandom_range(1) ? 8'hff : 8'h00, 8'($urandom_range(12) - 6));
      else exec_op(op, hi, 8'($urandom));
    end
  endtask

  initial begin
    int po, pu, ln;
    for (int i = 0; i < 256; i++)
      if (exec_scoreboard::decode(8'(i), po, pu, ln)) known_ops.push_back(8'(i));
    rst_n = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    in_tvalid = 0; in_tdata = 0; out_tready = 0;
    tx_idle_pct = 0; rx_stall_pct = 0; hold_go = 0; push_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, overflow cases and the stack, local, unsupported and divide faults.
    send(item(ACT_START, 0, 0, 0, 0, 0));
    send(item(ACT_LOAD, 0, 0, 0, 5'd0, 32'h8000_0000));
    send(item(ACT_LOAD, 8'hff, 8'hff, 8'hff, 5'd31, 32'h7fff_ffff));
    exec_op(OP_POP);                 // stack underflow
    exec_op(OP_ILOAD, 8'd40);        // local index out of range
    exec_op(8'hff);                  // unsupported opcode
    exec_op(OP_ILOAD, 8'd31);
    exec_op(OP_ICONST_M1);
    exec_op(OP_IADD);                // adds minus one to the largest positive value
    exec_op(OP_ILOAD_0);
    exec_op(OP_ICONST_M1);
    exec_op(OP_IDIV);                // most negative over minus one
    exec_op(OP_ICONST_0);
    exec_op(OP_IREM);                // division by zero
    exec_op(OP_SIPUSH, 8'h80, 8'h00);
    exec_op(OP_BIPUSH, 8'h7f);
    exec_op(OP_ISHR);
    exec_op(OP_IINC, 8'd31, 8'h80);
    exec_op(OP_GOTO, 8'hff, 8'he0);  // backward branch wrapping below zero
    exec_op(OP_IRETURN);
    exec_op(OP_RETURN);
    send(item(ACT_SPARE, 0, 0, 0, 0, 0));
    drain();

    // Code length of one and limit of one: end of code and timeout.
    write_reg(CFG_CODE_LENGTH, 21'd1);
    write_reg(CFG_INSTR_LIMIT, 21'd1);
    send(item(ACT_START, 0, 0, 0, 0, 0));
    exec_op(OP_NOP);
    exec_op(OP_NOP);
    send(item(ACT_START, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_CODE_LENGTH, 21'd65535);
    exec_op(OP_NOP);
    exec_op(OP_NOP);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 51; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      write_reg(CFG_CODE_LENGTH, (phase == 1) ? 21'd200 : 21'd65535);
      write_reg(CFG_INSTR_LIMIT, (phase == 2) ? 21'd40 : 21'd2000000);
      send(item(ACT_START, 0, 0, 0, 0, 0));
      for (int n = 0; n < 320; n++) begin
        if (phase == 0 && n == 100) hold_go = 1;
        if (n == 200) drain();
        if (push_left == 0 && $urandom_range(199) == 0) push_left = $urandom_range(240, 270);
        random_item();
      end
      push_left = 0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
